/* hw/rtl/short_preamble_sync_derotate_macros.svh */
// Assertion macros for the short preamble synchronizer.
`ifndef SHORT_PREAMBLE_SYNC_DEROTATE_MACROS_SVH
`define SHORT_PREAMBLE_SYNC_DEROTATE_MACROS_SVH
`ifndef SYNTH
`define SPSD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SPSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SPSD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SPSD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/spsd_pkg.sv */
// Shared types, constants and tables for the short preamble synchronizer.
`timescale 1ns / 1ps
package spsd_pkg;
   localparam int MaxOutDefault      = 8192;
   localparam int MaxInDefault       = 32768;
   localparam int CordicStagesDefault = 16;
   localparam int ValW   = 32;   // CORDIC datapath width
   localparam int AngW   = 25;   // CORDIC angle width
   localparam logic [15:0] ThresholdReset = 16'd18350;
   localparam logic [2:0]  PlateauLenReset = 3'd2;
   localparam logic signed [19:0] OffLimit = 20'sd262144;
   localparam logic signed [31:0] InvGainQ30 = 32'sd652032874;

   typedef enum logic [1:0] {
      REG_THRESHOLD   = 2'd0,
      REG_PLATEAU_LEN = 2'd1
   } reg_index_type;

   // Control states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE, ST_VEC, ST_OFF, ST_ROT, ST_MUL, ST_OUT
   } state_type;

   // One CORDIC cell's payload.
   typedef struct packed {
      logic              valid;
      logic              vec;      // vectoring (offset) versus rotation
      logic signed [ValW-1:0] x;
      logic signed [ValW-1:0] y;
      logic signed [AngW-1:0] z;
   } cell_data_type;

   // Side information that travels with a rotation through the chain.
   typedef struct packed {
      logic              run_end;
      logic signed [19:0] offset;
   } tag_type;

   function automatic logic signed [AngW-1:0] atan_lookup(input logic [4:0] i);
      logic signed [AngW-1:0] r;
      case (i)
         5'd0:  r = 25'sd2097152;  5'd1:  r = 25'sd1238021;
         5'd2:  r = 25'sd654136;   5'd3:  r = 25'sd332050;
         5'd4:  r = 25'sd166669;   5'd5:  r = 25'sd83416;
         5'd6:  r = 25'sd41718;    5'd7:  r = 25'sd20860;
         5'd8:  r = 25'sd10430;    5'd9:  r = 25'sd5215;
         5'd10: r = 25'sd2608;     5'd11: r = 25'sd1304;
         5'd12: r = 25'sd652;      5'd13: r = 25'sd326;
         5'd14: r = 25'sd163;      5'd15: r = 25'sd81;
         5'd16: r = 25'sd41;       5'd17: r = 25'sd20;
         5'd18: r = 25'sd10;       5'd19: r = 25'sd5;
         5'd20: r = 25'sd3;        5'd21: r = 25'sd1;
         5'd22: r = 25'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction
endpackage

/* hw/rtl/spsd_if.sv */
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
interface spsd_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_re;
   logic signed [15:0] sample_im;
   logic signed [15:0] autocorr_re;
   logic signed [15:0] autocorr_im;
   logic [15:0]        corr_level;
   logic               block_end;
   modport source (output valid, sample_re, sample_im, autocorr_re, autocorr_im,
                   corr_level, block_end, input ready);
   modport sink (input valid, sample_re, sample_im, autocorr_re, autocorr_im,
                 corr_level, block_end, output ready);
endinterface

interface spsd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_re;
   logic signed [15:0] out_im;
   logic signed [19:0] offset_angle;
   logic               status;
   logic               run_end;
   modport source (output valid, out_re, out_im, offset_angle, status, run_end,
                   input ready);
   modport sink (input valid, out_re, out_im, offset_angle, status, run_end,
                 output ready);
endinterface

/* hw/rtl/short_preamble_sync_derotate.sv */
// Top level: plateau detection, offset estimate and derotation of a sample stream.
//   channel | direction | handshake      | payload
//   req     | in        | valid/ready    | sample, autocorrelation, level, block end
//   rsp     | out       | valid/ready    | derotated sample, offset, status, run end
//   csr     | in        | APB write/read | threshold, plateau length
// With N = min(CordicStages, 24) cells, an item without a result returns straight to idle,
// a no-frame result goes to the output register, a derotated sample makes one pass through
// the cell row and the frame start makes a vectoring pass, then a rotation pass.
// One item is in flight at a time; a finished result moves into the output register, and
// a new result waits only while that register still holds an unaccepted transaction.
// Reset is synchronous; it clears control state, counters, settings and output valid.
`timescale 1ns / 1ps
`include "short_preamble_sync_derotate_macros.svh"
module short_preamble_sync_derotate #(
   parameter int MaxOut       = spsd_pkg::MaxOutDefault,
   parameter int MaxIn        = spsd_pkg::MaxInDefault,
   parameter int CordicStages = spsd_pkg::CordicStagesDefault
) (
   input  logic        clock,
   input  logic        reset,
   spsd_req_if.sink    req,
   spsd_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int IdxW = $clog2(MaxIn + 1);
   localparam int CntW = $clog2(MaxOut + 1);

   spsd_pkg::state_type state_ff, state_in;
   logic [15:0] threshold_ff;
   logic [2:0]  plateau_len_ff, plateau_ff;
   logic        found_ff;
   logic signed [19:0] offset_ff;
   logic [23:0] phase_ff;
   logic [IdxW-1:0] index_ff;
   logic [CntW-1:0] emitted_ff;

   // Held request payload.
   logic signed [15:0] s_re_ff, s_im_ff, a_re_ff, a_im_ff;
   logic [15:0] level_ff;
   logic        last_ff;

   // Block index and rotation phase of the item in the cell row.
   logic [IdxW-1:0] k_ff;
   logic [23:0] rot_phase_ff;

   logic signed [63:0] px_ff, py_ff;
   logic signed [15:0] o_re_ff, o_im_ff;
   logic signed [19:0] o_off_ff;
   logic        o_st_ff, o_end_ff, rsp_valid_ff;
   spsd_pkg::tag_type tag_ff;

   logic        accept, cfg_wr, out_free, out_load;
   spsd_pkg::reg_index_type reg_idx;
   logic        chain_go;
   spsd_pkg::cell_data_type c_in, c_out;
   spsd_pkg::tag_type       ct_in, ct_out;
   logic [5:0]  cnt_ff;
   localparam int N = (CordicStages > 24) ? 24 : CordicStages;

   assign accept = req.valid && req.ready;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign reg_idx = spsd_pkg::reg_index_type'({1'b0, csr_paddr[2]});
   assign out_free = !rsp_valid_ff || rsp.ready;

   // Register read mux.
   always_comb begin
      case (reg_idx)
         spsd_pkg::REG_THRESHOLD: csr_prdata = {16'd0, threshold_ff};
         default:                 csr_prdata = {29'd0, plateau_len_ff};
      endcase
   end

   // Per-item decisions taken from the held item.
   logic in_range, above, start, emit;
   always_comb begin
      in_range = index_ff < IdxW'(MaxIn);
      above    = level_ff > threshold_ff;
      start    = in_range && !found_ff && above && (plateau_ff >= plateau_len_ff);
      emit     = in_range && (found_ff || start) && (emitted_ff < CntW'(MaxOut));
   end

   // Vectoring offset pre-processing.
   logic signed [31:0] vx, vy;
   always_comb begin
      vx = 32'(a_re_ff < 0 ? -34'(a_re_ff) : 34'(a_re_ff)) <<< 14;
      vy = 32'(a_re_ff < 0 ? -34'(a_im_ff) : 34'(a_im_ff)) <<< 14;
   end

   // Offset from the vectoring angle: /16 rounded, clamped, special cases.
   logic signed [19:0] off_calc;
   logic signed [24:0] zr;
   always_comb begin
      zr = (c_out.z + 25'sd8) >>> 4;
      if (a_re_ff == 0)
         off_calc = (a_im_ff > 0) ? spsd_pkg::OffLimit :
                    (a_im_ff < 0) ? -spsd_pkg::OffLimit : '0;
      else if (a_im_ff == 0)
         off_calc = '0;
      else if (zr > 25'(spsd_pkg::OffLimit))
         off_calc = spsd_pkg::OffLimit;
      else if (zr < -25'(spsd_pkg::OffLimit))
         off_calc = -spsd_pkg::OffLimit;
      else
         off_calc = 20'(zr);
   end

   // Phase of the frame start item: minus the offset times its block index.
   logic [23:0] start_phase;
   assign start_phase = 24'd0 - 24'(off_calc) * 24'(k_ff);

   // Rotation input with quadrant fold; phase held for the item in the row.
   logic [23:0] rphase;
   logic signed [24:0] rz;
   logic signed [31:0] rx, ry;
   always_comb begin
      rphase = rot_phase_ff;
      rz = 25'(signed'(rphase));
      rx = 32'(s_re_ff) <<< 14;
      ry = 32'(s_im_ff) <<< 14;
      if (rz > 25'sh400000) begin
         rx = -rx; ry = -ry; rz = rz - 25'sh800000;
      end else if (rz < -25'sh400000) begin
         rx = -rx; ry = -ry; rz = rz + 25'sh800000;
      end
   end

   // Feed to the cell row.
   always_comb begin
      c_in = '0;
      ct_in = tag_ff;
      if (state_ff == spsd_pkg::ST_VEC && cnt_ff == '0) begin
         c_in.valid = 1'b1; c_in.vec = 1'b1; c_in.x = vx; c_in.y = vy;
      end else if (state_ff == spsd_pkg::ST_ROT && cnt_ff == '0) begin
         c_in.valid = 1'b1; c_in.x = rx; c_in.y = ry; c_in.z = rz;
      end
   end
   assign chain_go = 1'b1;

   spsd_chain #(.Stages(CordicStages)) u_chain (
      .clock(clock), .reset(reset), .advance(chain_go),
      .d_in(c_in), .t_in(ct_in), .d_out(c_out), .t_out(ct_out));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spsd_pkg::ST_IDLE: if (accept) state_in = spsd_pkg::ST_OFF;
         spsd_pkg::ST_OFF: begin
            if (start)      state_in = spsd_pkg::ST_VEC;
            else if (emit)  state_in = spsd_pkg::ST_ROT;
            else if (last_ff && !found_ff) state_in = spsd_pkg::ST_OUT;
            else            state_in = spsd_pkg::ST_IDLE;
         end
         spsd_pkg::ST_VEC: if (c_out.valid && c_out.vec) state_in = spsd_pkg::ST_ROT;
         spsd_pkg::ST_ROT: if (c_out.valid && !c_out.vec) state_in = spsd_pkg::ST_MUL;
         spsd_pkg::ST_MUL: if (out_free) state_in = spsd_pkg::ST_IDLE;
         spsd_pkg::ST_OUT: if (out_free) state_in = spsd_pkg::ST_IDLE;
         default: state_in = spsd_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      req.ready = (state_ff == spsd_pkg::ST_IDLE);
      out_load  = (state_ff == spsd_pkg::ST_MUL || state_ff == spsd_pkg::ST_OUT) && out_free;
   end
   assign rsp.valid = rsp_valid_ff;

   // Gain compensation, rounding and saturation.
   function automatic logic signed [15:0] sat(input logic signed [63:0] p);
      logic signed [63:0] r;
      r = (p + (64'sd1 <<< 43)) >>> 44;
      if (r > 64'sd32767)       return 16'sd32767;
      else if (r < -64'sd32768) return -16'sd32768;
      else                      return 16'(r);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spsd_pkg::ST_IDLE;
         threshold_ff <= spsd_pkg::ThresholdReset;
         plateau_len_ff <= spsd_pkg::PlateauLenReset;
         plateau_ff <= '0; found_ff <= 1'b0; offset_ff <= '0; phase_ff <= '0;
         index_ff <= '0; emitted_ff <= '0; cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cfg_wr) begin
            case (reg_idx)
               spsd_pkg::REG_THRESHOLD: threshold_ff <= csr_pwdata[15:0];
               default:                 plateau_len_ff <= csr_pwdata[2:0];
            endcase
         end
         cnt_ff <= (state_ff != state_in) ? '0 : ((cnt_ff == '1) ? cnt_ff : cnt_ff + 6'd1);
         if (accept) begin
            s_re_ff <= req.sample_re; s_im_ff <= req.sample_im;
            a_re_ff <= req.autocorr_re; a_im_ff <= req.autocorr_im;
            level_ff <= req.corr_level; last_ff <= req.block_end;
         end
         // Block bookkeeping once per item; the rotation uses the phase before the step.
         if (state_ff == spsd_pkg::ST_OFF) begin
            tag_ff.offset <= offset_ff;
            tag_ff.run_end <= last_ff || (emitted_ff + CntW'(1) >= CntW'(MaxOut));
            rot_phase_ff <= phase_ff;
            k_ff <= index_ff;
            if (last_ff) begin
               plateau_ff <= '0; found_ff <= 1'b0; offset_ff <= '0;
               phase_ff <= '0; index_ff <= '0; emitted_ff <= '0;
            end else begin
               if (in_range && !found_ff && !start)
                  plateau_ff <= above ? plateau_ff + 3'd1 : 3'd0;
               if (in_range) index_ff <= index_ff + IdxW'(1);
               if (emit) emitted_ff <= emitted_ff + CntW'(1);
               if (in_range && found_ff) phase_ff <= phase_ff - 24'(offset_ff);
            end
         end
         // Frame start: set the offset, rotate this item, step the phase past it if not last.
         if (state_ff == spsd_pkg::ST_VEC && c_out.valid && c_out.vec) begin
            tag_ff.offset <= off_calc;
            rot_phase_ff <= start_phase;
            if (!last_ff) begin
               found_ff <= 1'b1;
               offset_ff <= off_calc;
               phase_ff <= start_phase - 24'(off_calc);
            end
         end
         if (state_ff == spsd_pkg::ST_ROT && c_out.valid && !c_out.vec) begin
            px_ff <= 64'(c_out.x) * 64'(spsd_pkg::InvGainQ30);
            py_ff <= 64'(c_out.y) * 64'(spsd_pkg::InvGainQ30);
         end
         // Output register: loads a finished result once the previous one has left.
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            if (state_ff == spsd_pkg::ST_MUL) begin
               o_re_ff <= sat(px_ff); o_im_ff <= sat(py_ff);
               o_off_ff <= ct_out.offset; o_st_ff <= 1'b0; o_end_ff <= ct_out.run_end;
            end else begin
               o_re_ff <= '0; o_im_ff <= '0; o_off_ff <= '0;
               o_st_ff <= 1'b1; o_end_ff <= 1'b1;
            end
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp.out_re = o_re_ff;
   assign rsp.out_im = o_im_ff;
   assign rsp.offset_angle = o_off_ff;
   assign rsp.status = o_st_ff;
   assign rsp.run_end = o_end_ff;

   `SPSD_ASSERT_NEXT(a_out_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid)
   `SPSD_ASSERT_NEXT(a_out_stable, clock, reset, rsp.valid && !rsp.ready, $stable(o_re_ff) && $stable(o_im_ff) && $stable(o_off_ff) && $stable(o_st_ff) && $stable(o_end_ff))
   `SPSD_ASSERT_IMPL(a_rot_latency, clock, reset, state_ff == spsd_pkg::ST_ROT && cnt_ff == 6'(N), c_out.valid)
   `SPSD_ASSERT_IMPL(a_emit_bound, clock, reset, 1'b1, emitted_ff <= CntW'(MaxOut))
endmodule

/* hw/rtl/spsd_cell.sv */
// One CORDIC micro-rotation cell; vectoring or rotation mode per transaction.
`timescale 1ns / 1ps
module spsd_cell #(
   parameter int Index = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  spsd_pkg::cell_data_type d_in,
   input  spsd_pkg::tag_type       t_in,
   output spsd_pkg::cell_data_type d_out,
   output spsd_pkg::tag_type       t_out
);
   spsd_pkg::cell_data_type d_ff, d_in_c;
   spsd_pkg::tag_type       t_ff;
   logic signed [spsd_pkg::ValW-1:0] xs, ys;
   logic signed [spsd_pkg::AngW-1:0] a;
   logic                              dir;

   // Micro-rotation: arithmetic shifts floor like the model.
   always_comb begin
      xs = d_in.x >>> Index;
      ys = d_in.y >>> Index;
      a  = spsd_pkg::atan_lookup(5'(Index));
      dir = d_in.vec ? (d_in.y > 0) : !d_in.z[spsd_pkg::AngW-1];
      d_in_c = d_in;
      if (d_in.vec) begin
         d_in_c.x = dir ? d_in.x + ys : d_in.x - ys;
         d_in_c.y = dir ? d_in.y - xs : d_in.y + xs;
         d_in_c.z = dir ? d_in.z + a  : d_in.z - a;
      end else begin
         d_in_c.x = dir ? d_in.x - ys : d_in.x + ys;
         d_in_c.y = dir ? d_in.y + xs : d_in.y - xs;
         d_in_c.z = dir ? d_in.z - a  : d_in.z + a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.valid <= 1'b0;
      end else if (advance) begin
         d_ff <= d_in_c;
         t_ff <= t_in;
      end
   end

   assign d_out = d_ff;
   assign t_out = t_ff;
endmodule

/* hw/rtl/spsd_chain.sv */
// Row of CORDIC cells shared by offset estimation and derotation.
`timescale 1ns / 1ps
module spsd_chain #(
   parameter int Stages = spsd_pkg::CordicStagesDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  spsd_pkg::cell_data_type d_in,
   input  spsd_pkg::tag_type       t_in,
   output spsd_pkg::cell_data_type d_out,
   output spsd_pkg::tag_type       t_out
);
   localparam int N = (Stages > 24) ? 24 : Stages;
   spsd_pkg::cell_data_type d [N+1];
   spsd_pkg::tag_type       t [N+1];

   assign d[0] = d_in;
   assign t[0] = t_in;
   for (genvar g = 0; g < N; g++) begin : g_cell
      spsd_cell #(.Index(g)) u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .d_in(d[g]), .t_in(t[g]), .d_out(d[g+1]), .t_out(t[g+1]));
   end
   assign d_out = d[N];
   assign t_out = t[N];
endmodule
